// ===== design/lup_pkg.sv =====
// Shared types, codes and defaults for the LUP linear solver.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lup_pkg;

    localparam int DEF_MAX_N     = 8;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DATA_W        = 32;
    localparam int SIZE_W        = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // Request kinds carried on s_tuser.
    localparam logic [1:0] MODE_MTX   = 2'd0;
    localparam logic [1:0] MODE_RHS   = 2'd1;
    localparam logic [1:0] MODE_SOLVE = 2'd2;

    // Matrix address sources (row, column).
    localparam logic [2:0] ASEL_IN = 3'd0;
    localparam logic [2:0] ASEL_IK = 3'd1;
    localparam logic [2:0] ASEL_KJ = 3'd2;
    localparam logic [2:0] ASEL_IJ = 3'd3;
    localparam logic [2:0] ASEL_PJ = 3'd4;
    localparam logic [2:0] ASEL_KK = 3'd5;
    localparam logic [2:0] ASEL_II = 3'd6;

    // Matrix write data sources.
    localparam logic [2:0] WD_IN  = 3'd0;
    localparam logic [2:0] WD_RD  = 3'd1;
    localparam logic [2:0] WD_TMP = 3'd2;
    localparam logic [2:0] WD_DIV = 3'd3;
    localparam logic [2:0] WD_SUB = 3'd4;

    // Work vector read index sources.
    localparam logic [1:0] WK_I    = 2'd0;
    localparam logic [1:0] WK_J    = 2'd1;
    localparam logic [1:0] WK_K    = 2'd2;
    localparam logic [1:0] WK_PICK = 2'd3;

    localparam logic MUL_LF_RD  = 1'b0;
    localparam logic MUL_RD_WK  = 1'b1;
    localparam logic SUB_RD     = 1'b0;
    localparam logic SUB_ACC    = 1'b1;
    localparam logic DIV_RD_PIV = 1'b0;
    localparam logic DIV_ACC_RD = 1'b1;

    typedef struct packed {
        logic       ram_we;
        logic [2:0] rd_sel;
        logic [2:0] wr_sel;
        logic [2:0] wd_sel;
        logic       rhs_we;
        logic       copy_rhs;
        logic       piv_init;
        logic       piv_cmp;
        logic       set_sing;
        logic       clr_sing;
        logic       tmp_ld_rd;
        logic       tmp_ld_wk;
        logic [1:0] wk_sel;
        logic       wk_swap;
        logic       piv_ld;
        logic       lfac_ld;
        logic       mul_ld;
        logic       mul_src;
        logic       acc_ld_wk;
        logic       acc_ld_sub;
        logic       sub_src;
        logic       wk_ld_acc;
        logic       wk_ld_div;
        logic       div_start;
        logic       div_src;
        logic       out_ld;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic best_zero;
        logic pick_is_k;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== design/lup_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the coefficient matrix; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module lup_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/lup_div.sv =====
// Radix-2 restoring divider: (num * 2^FRAC_BITS) / den, truncated toward zero,
// saturated to 32 bits; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module lup_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [31:0]      quo
);

    localparam int DW    = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    dvd_reg, dvd_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      dvs_reg, dvs_next;
    logic             neg_reg, neg_next;
    logic [32:0]      trial;
    logic [31:0]      num_mag, den_mag;
    logic             over_pos, over_neg;

    assign num_mag = num[31] ? (~num + 32'd1) : num;
    assign den_mag = den[31] ? (~den + 32'd1) : den;
    assign trial   = {rem_reg, dvd_reg[DW-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
            dvd_next  = {num_mag, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            dvs_next  = den_mag;
            neg_next  = num[31] ^ den[31];
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = 32'(trial - {1'b0, dvs_reg});
                dvd_next = {dvd_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                dvd_next = {dvd_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // A negative result may reach -2^31; a positive one stops at 2^31 - 1.
    assign over_pos = |dvd_reg[DW-1:31];
    assign over_neg = (|dvd_reg[DW-1:32]) || (dvd_reg[31] && (|dvd_reg[30:0]));

    always_comb begin
        if (neg_reg) begin
            quo = over_neg ? 32'h8000_0000 : (~dvd_reg[31:0] + 32'd1);
        end else begin
            quo = over_pos ? 32'h7FFF_FFFF : dvd_reg[31:0];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== design/lup_datapath.sv =====
// Solver datapath: matrix RAM, right-hand side and work vector registers,
// multiplier, saturating subtractor, divider and output register.
// Depends on lup_pkg, lup_ram and lup_div.
`timescale 1ns / 1ps
`default_nettype none

module lup_datapath
    import lup_pkg::*;
#(
    parameter int MAX_N     = DEF_MAX_N,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire cmd_t                     cmd,
    output stat_t                         stat,
    input  wire logic [$clog2(MAX_N)-1:0] cur_i,
    input  wire logic [$clog2(MAX_N)-1:0] cur_j,
    input  wire logic [$clog2(MAX_N)-1:0] cur_k,
    input  wire logic [2:0]               in_row,
    input  wire logic [2:0]               in_col,
    input  wire logic [DATA_W-1:0]        in_value,
    input  wire logic                     m_ready,
    output logic                          m_valid,
    output logic [DATA_W-1:0]             m_value,
    output logic [2:0]                    m_index,
    output logic                          m_last,
    output logic                          m_sing
);

    localparam int IW    = $clog2(MAX_N);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;

    logic [AW-1:0]     raddr, waddr;
    logic [DATA_W-1:0] wdata, rd;
    logic [DATA_W-1:0] rhs_reg [MAX_N];
    logic [DATA_W-1:0] work_reg [MAX_N];
    logic [IW-1:0]     wk_idx;
    logic [DATA_W-1:0] wk_rd;
    logic [DATA_W-1:0] best_reg, rd_mag;
    logic [IW-1:0]     pick_reg;
    logic [DATA_W-1:0] tmp_reg, piv_reg, lfac_reg, acc_reg;
    logic signed [63:0] prod_reg, mshift;
    logic signed [31:0] mul_a, mul_b;
    logic [DATA_W-1:0] mval, minu, sub_res;
    logic [DATA_W:0]   diff;
    logic              div_done;
    logic [DATA_W-1:0] div_q, div_num, div_den;
    logic              sing_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [2:0]        out_index_reg;
    logic              out_last_reg, out_sing_reg;

    function automatic logic [AW-1:0] addr_of(
        input logic [2:0]    sel,
        input logic [IW-1:0] i, j, k, p,
        input logic [2:0]    r, c
    );
        logic [AW-1:0] a;
        case (sel)
            ASEL_IN: a = {IW'(r), IW'(c)};
            ASEL_IK: a = {i, k};
            ASEL_KJ: a = {k, j};
            ASEL_IJ: a = {i, j};
            ASEL_PJ: a = {p, j};
            ASEL_KK: a = {k, k};
            ASEL_II: a = {i, i};
            default: a = '0;
        endcase
        return a;
    endfunction

    assign raddr = addr_of(cmd.rd_sel, cur_i, cur_j, cur_k, pick_reg, in_row, in_col);
    assign waddr = addr_of(cmd.wr_sel, cur_i, cur_j, cur_k, pick_reg, in_row, in_col);

    always_comb begin
        case (cmd.wd_sel)
            WD_IN:   wdata = in_value;
            WD_RD:   wdata = rd;
            WD_TMP:  wdata = tmp_reg;
            WD_DIV:  wdata = div_q;
            WD_SUB:  wdata = sub_res;
            default: wdata = rd;
        endcase
    end

    lup_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_mtx (
        .aclk  (aclk),
        .we    (cmd.ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd)
    );

    always_comb begin
        case (cmd.wk_sel)
            WK_I:    wk_idx = cur_i;
            WK_J:    wk_idx = cur_j;
            WK_K:    wk_idx = cur_k;
            WK_PICK: wk_idx = pick_reg;
            default: wk_idx = cur_i;
        endcase
    end
    assign wk_rd = work_reg[wk_idx];

    // Fixed-point product: floor shift, then saturate to 32 bits.
    assign mshift = prod_reg >>> FRAC_BITS;
    always_comb begin
        if ((&mshift[63:31]) || !(|mshift[63:31])) begin
            mval = mshift[31:0];
        end else begin
            mval = mshift[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    assign minu = (cmd.sub_src == SUB_ACC) ? acc_reg : rd;
    assign diff = {minu[31], minu} - {mval[31], mval};
    always_comb begin
        if (diff[32] != diff[31]) begin
            sub_res = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sub_res = diff[31:0];
        end
    end

    assign mul_a = (cmd.mul_src == MUL_RD_WK) ? $signed(rd) : $signed(lfac_reg);
    assign mul_b = (cmd.mul_src == MUL_RD_WK) ? $signed(wk_rd) : $signed(rd);

    assign div_num = (cmd.div_src == DIV_ACC_RD) ? acc_reg : rd;
    assign div_den = (cmd.div_src == DIV_ACC_RD) ? rd : piv_reg;

    lup_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    assign rd_mag = rd[31] ? (~rd + 32'd1) : rd;

    always_ff @(posedge aclk) begin
        if (cmd.rhs_we) begin
            rhs_reg[IW'(in_row)] <= in_value;
        end
        for (int e = 0; e < MAX_N; e++) begin
            if (cmd.copy_rhs) begin
                work_reg[e] <= rhs_reg[e];
            end else if (cmd.wk_swap && (IW'(e) == pick_reg)) begin
                work_reg[e] <= wk_rd;
            end else if (cmd.wk_swap && (IW'(e) == cur_k)) begin
                work_reg[e] <= tmp_reg;
            end else if (cmd.wk_ld_acc && (IW'(e) == cur_i)) begin
                work_reg[e] <= acc_reg;
            end else if (cmd.wk_ld_div && (IW'(e) == cur_i)) begin
                work_reg[e] <= div_q;
            end
        end
        if (cmd.piv_init) begin
            best_reg <= '0;
            pick_reg <= cur_k;
        end else if (cmd.piv_cmp && (rd_mag > best_reg)) begin
            best_reg <= rd_mag;
            pick_reg <= cur_i;
        end
        if (cmd.tmp_ld_rd) begin
            tmp_reg <= rd;
        end else if (cmd.tmp_ld_wk) begin
            tmp_reg <= wk_rd;
        end
        if (cmd.piv_ld) begin
            piv_reg <= rd;
        end
        if (cmd.lfac_ld) begin
            lfac_reg <= div_q;
        end
        if (cmd.mul_ld) begin
            prod_reg <= 64'(mul_a * mul_b);
        end
        if (cmd.acc_ld_wk) begin
            acc_reg <= wk_rd;
        end else if (cmd.acc_ld_sub) begin
            acc_reg <= sub_res;
        end
        if (cmd.out_ld) begin
            out_value_reg <= sing_reg ? '0 : wk_rd;
            out_index_reg <= 3'(cur_i);
            out_last_reg  <= cmd.out_last;
            out_sing_reg  <= sing_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sing_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_sing) begin
                sing_reg <= 1'b0;
            end else if (cmd.set_sing) begin
                sing_reg <= 1'b1;
            end
            if (cmd.out_ld) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.best_zero = (best_reg == '0);
    assign stat.pick_is_k = (pick_reg == cur_k);
    assign stat.div_done  = div_done;
    assign stat.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_value = out_value_reg;
    assign m_index = out_index_reg;
    assign m_last  = out_last_reg;
    assign m_sing  = out_sing_reg;

endmodule

`default_nettype wire

// ===== design/lup_ctrl.sv =====
// Solver controller: order register, loop counters and the sequencer that
// drives the datapath through decomposition, substitution and output.
// Depends on lup_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lup_ctrl
    import lup_pkg::*;
#(
    parameter int MAX_N = DEF_MAX_N
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [SIZE_W-1:0]        cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               in_mode,
    input  wire logic [2:0]               in_row,
    input  wire logic [2:0]               in_col,
    input  wire stat_t                    stat,
    output cmd_t                          cmd,
    output logic [$clog2(MAX_N)-1:0]      cur_i,
    output logic [$clog2(MAX_N)-1:0]      cur_j,
    output logic [$clog2(MAX_N)-1:0]      cur_k
);

    localparam int IW = $clog2(MAX_N);
    localparam int CW = $clog2(MAX_N + 1);

    localparam logic [5:0] ST_IDLE    = 6'd0;
    localparam logic [5:0] ST_PS_INIT = 6'd1;
    localparam logic [5:0] ST_PS_RD   = 6'd2;
    localparam logic [5:0] ST_PS_CMP  = 6'd3;
    localparam logic [5:0] ST_PS_CHK  = 6'd4;
    localparam logic [5:0] ST_SW_A    = 6'd5;
    localparam logic [5:0] ST_SW_B    = 6'd6;
    localparam logic [5:0] ST_SW_C    = 6'd7;
    localparam logic [5:0] ST_SW_D    = 6'd8;
    localparam logic [5:0] ST_WS_A    = 6'd9;
    localparam logic [5:0] ST_WS_B    = 6'd10;
    localparam logic [5:0] ST_EL_P    = 6'd11;
    localparam logic [5:0] ST_EL_P2   = 6'd12;
    localparam logic [5:0] ST_EL_I    = 6'd13;
    localparam logic [5:0] ST_EL_I2   = 6'd14;
    localparam logic [5:0] ST_EL_DIV  = 6'd15;
    localparam logic [5:0] ST_EL_J    = 6'd16;
    localparam logic [5:0] ST_EL_J2   = 6'd17;
    localparam logic [5:0] ST_EL_J3   = 6'd18;
    localparam logic [5:0] ST_K_NEXT  = 6'd19;
    localparam logic [5:0] ST_FW_I    = 6'd20;
    localparam logic [5:0] ST_FW_RD   = 6'd21;
    localparam logic [5:0] ST_FW_MUL  = 6'd22;
    localparam logic [5:0] ST_FW_SUB  = 6'd23;
    localparam logic [5:0] ST_FW_W    = 6'd24;
    localparam logic [5:0] ST_BK_I    = 6'd25;
    localparam logic [5:0] ST_BK_RD   = 6'd26;
    localparam logic [5:0] ST_BK_MUL  = 6'd27;
    localparam logic [5:0] ST_BK_SUB  = 6'd28;
    localparam logic [5:0] ST_BK_P    = 6'd29;
    localparam logic [5:0] ST_BK_P2   = 6'd30;
    localparam logic [5:0] ST_BK_DIV  = 6'd31;
    localparam logic [5:0] ST_EMIT    = 6'd32;

    logic [5:0]        state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CW-1:0]     i_inc, j_inc, k_inc;
    logic              row_ok, col_ok;

    assign i_inc  = CW'(i_reg + 1'b1);
    assign j_inc  = CW'(j_reg + 1'b1);
    assign k_inc  = CW'(k_reg + 1'b1);
    assign row_ok = (int'(in_row) < MAX_N);
    assign col_ok = (int'(in_col) < MAX_N);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (in_mode)
                        MODE_MTX: begin
                            cmd.ram_we = row_ok && col_ok;
                            cmd.wr_sel = ASEL_IN;
                            cmd.wd_sel = WD_IN;
                        end
                        MODE_RHS: begin
                            cmd.rhs_we = row_ok;
                        end
                        MODE_SOLVE: begin
                            if (size_reg == '0) begin
                                n_next = CW'(1);
                            end else if (int'(size_reg) > MAX_N) begin
                                n_next = CW'(MAX_N);
                            end else begin
                                n_next = CW'(size_reg);
                            end
                            cmd.copy_rhs = 1'b1;
                            cmd.clr_sing = 1'b1;
                            k_next       = '0;
                            state_next   = ST_PS_INIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PS_INIT: begin
                cmd.piv_init = 1'b1;
                i_next       = k_reg;
                state_next   = ST_PS_RD;
            end
            ST_PS_RD: begin
                cmd.rd_sel = ASEL_IK;
                state_next = ST_PS_CMP;
            end
            ST_PS_CMP: begin
                cmd.piv_cmp = 1'b1;
                if (i_inc < n_reg) begin
                    i_next     = i_inc;
                    state_next = ST_PS_RD;
                end else begin
                    state_next = ST_PS_CHK;
                end
            end
            ST_PS_CHK: begin
                if (stat.best_zero) begin
                    cmd.set_sing = 1'b1;
                    i_next       = '0;
                    state_next   = ST_EMIT;
                end else if (!stat.pick_is_k) begin
                    j_next     = '0;
                    state_next = ST_SW_A;
                end else begin
                    state_next = ST_EL_P;
                end
            end
            ST_SW_A: begin
                cmd.rd_sel = ASEL_PJ;
                state_next = ST_SW_B;
            end
            ST_SW_B: begin
                cmd.rd_sel    = ASEL_KJ;
                cmd.tmp_ld_rd = 1'b1;
                state_next    = ST_SW_C;
            end
            ST_SW_C: begin
                cmd.ram_we = 1'b1;
                cmd.wr_sel = ASEL_PJ;
                cmd.wd_sel = WD_RD;
                state_next = ST_SW_D;
            end
            ST_SW_D: begin
                cmd.ram_we = 1'b1;
                cmd.wr_sel = ASEL_KJ;
                cmd.wd_sel = WD_TMP;
                j_next     = j_inc;
                state_next = (j_inc < n_reg) ? ST_SW_A : ST_WS_A;
            end
            ST_WS_A: begin
                cmd.wk_sel    = WK_PICK;
                cmd.tmp_ld_wk = 1'b1;
                state_next    = ST_WS_B;
            end
            ST_WS_B: begin
                cmd.wk_sel  = WK_K;
                cmd.wk_swap = 1'b1;
                state_next  = ST_EL_P;
            end
            ST_EL_P: begin
                cmd.rd_sel = ASEL_KK;
                state_next = ST_EL_P2;
            end
            ST_EL_P2: begin
                cmd.piv_ld = 1'b1;
                i_next     = k_inc;
                state_next = (k_inc < n_reg) ? ST_EL_I : ST_K_NEXT;
            end
            ST_EL_I: begin
                cmd.rd_sel = ASEL_IK;
                state_next = ST_EL_I2;
            end
            ST_EL_I2: begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DIV_RD_PIV;
                state_next    = ST_EL_DIV;
            end
            ST_EL_DIV: begin
                if (stat.div_done) begin
                    cmd.ram_we  = 1'b1;
                    cmd.wr_sel  = ASEL_IK;
                    cmd.wd_sel  = WD_DIV;
                    cmd.lfac_ld = 1'b1;
                    j_next      = k_inc;
                    state_next  = ST_EL_J;
                end
            end
            ST_EL_J: begin
                cmd.rd_sel = ASEL_KJ;
                state_next = ST_EL_J2;
            end
            ST_EL_J2: begin
                cmd.rd_sel  = ASEL_IJ;
                cmd.mul_ld  = 1'b1;
                cmd.mul_src = MUL_LF_RD;
                state_next  = ST_EL_J3;
            end
            ST_EL_J3: begin
                cmd.ram_we  = 1'b1;
                cmd.wr_sel  = ASEL_IJ;
                cmd.wd_sel  = WD_SUB;
                cmd.sub_src = SUB_RD;
                j_next      = j_inc;
                if (j_inc < n_reg) begin
                    state_next = ST_EL_J;
                end else if (i_inc < n_reg) begin
                    i_next     = i_inc;
                    state_next = ST_EL_I;
                end else begin
                    state_next = ST_K_NEXT;
                end
            end
            ST_K_NEXT: begin
                if (k_inc < n_reg) begin
                    k_next     = k_inc;
                    state_next = ST_PS_INIT;
                end else begin
                    i_next     = '0;
                    state_next = ST_FW_I;
                end
            end
            ST_FW_I: begin
                cmd.wk_sel    = WK_I;
                cmd.acc_ld_wk = 1'b1;
                j_next        = '0;
                state_next    = (i_reg == '0) ? ST_FW_W : ST_FW_RD;
            end
            ST_FW_RD: begin
                cmd.rd_sel = ASEL_IJ;
                state_next = ST_FW_MUL;
            end
            ST_FW_MUL: begin
                cmd.wk_sel  = WK_J;
                cmd.mul_ld  = 1'b1;
                cmd.mul_src = MUL_RD_WK;
                state_next  = ST_FW_SUB;
            end
            ST_FW_SUB: begin
                cmd.acc_ld_sub = 1'b1;
                cmd.sub_src    = SUB_ACC;
                j_next         = j_inc;
                state_next     = (j_inc < i_reg) ? ST_FW_RD : ST_FW_W;
            end
            ST_FW_W: begin
                cmd.wk_ld_acc = 1'b1;
                if (i_inc < n_reg) begin
                    i_next     = i_inc;
                    state_next = ST_FW_I;
                end else begin
                    i_next     = CW'(n_reg - 1'b1);
                    state_next = ST_BK_I;
                end
            end
            ST_BK_I: begin
                cmd.wk_sel    = WK_I;
                cmd.acc_ld_wk = 1'b1;
                j_next        = i_inc;
                state_next    = (i_inc < n_reg) ? ST_BK_RD : ST_BK_P;
            end
            ST_BK_RD: begin
                cmd.rd_sel = ASEL_IJ;
                state_next = ST_BK_MUL;
            end
            ST_BK_MUL: begin
                cmd.wk_sel  = WK_J;
                cmd.mul_ld  = 1'b1;
                cmd.mul_src = MUL_RD_WK;
                state_next  = ST_BK_SUB;
            end
            ST_BK_SUB: begin
                cmd.acc_ld_sub = 1'b1;
                cmd.sub_src    = SUB_ACC;
                j_next         = j_inc;
                state_next     = (j_inc < n_reg) ? ST_BK_RD : ST_BK_P;
            end
            ST_BK_P: begin
                cmd.rd_sel = ASEL_II;
                state_next = ST_BK_P2;
            end
            ST_BK_P2: begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DIV_ACC_RD;
                state_next    = ST_BK_DIV;
            end
            ST_BK_DIV: begin
                if (stat.div_done) begin
                    cmd.wk_ld_div = 1'b1;
                    if (i_reg == '0) begin
                        state_next = ST_EMIT;
                    end else begin
                        i_next     = CW'(i_reg - 1'b1);
                        state_next = ST_BK_I;
                    end
                end
            end
            ST_EMIT: begin
                cmd.wk_sel = WK_I;
                if (stat.out_free) begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_last = (i_inc == n_reg);
                    i_next       = i_inc;
                    if (i_inc == n_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            size_reg  <= SIZE_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
        end
        n_reg <= n_next;
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
    end

    assign cur_i = i_reg[IW-1:0];
    assign cur_j = j_reg[IW-1:0];
    assign cur_k = k_reg[IW-1:0];

endmodule

`default_nettype wire

// ===== design/lup_linear_solver.sv =====
// Top level of the LUP linear solver: stream ports, configuration register.
// Depends on lup_pkg, lup_ctrl and lup_datapath.
//
// Usage: software streams requests on the s_ channel. s_tuser carries the
// kind: write a matrix coefficient, write a right-hand side entry, or solve.
// Loads keep the sequencer idle and may follow back to back. A solve
// decomposes A in place with partial pivoting, then runs forward and back
// substitution and returns x[0..n-1] on the m_ channel, x[n-1] marked by
// m_tlast; m_tuser flags a singular system, in which case every returned
// value is zero. n comes from the order register (cfg_wr_en / cfg_wr_data,
// reset value 8). Solve time is set by the single matrix RAM port, which
// serializes each multiply-subtract, and by the bit-serial divider; row
// swaps in pivoting add to it. The first result is loaded into the output
// register in the EMIT state, entered once the last quotient is ready, then
// one result per cycle while m_tready does not stall. s_tready is high only
// while the sequencer is idle. A stall on m_tready holds the current result
// in the output register and pauses the output sequence. Reset returns the
// sequencer to idle, clears the output and the singular flag and sets n to
// 8; stored coefficients are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lup_linear_solver
    import lup_pkg::*;
#(
    parameter int MAX_N     = DEF_MAX_N,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [SIZE_W-1:0] cfg_wr_data,   // size_in_use
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [39:0]       s_tdata,       // row_index, col_index, entry_value
    input  wire logic [1:0]        s_tuser,       // mode
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,       // solution_value, solution_index
    output logic                   m_tlast,       // last_of_run
    output logic [0:0]             m_tuser        // singular
);

    localparam int IW = $clog2(MAX_N);

    cmd_t              cmd;
    stat_t             stat;
    logic [IW-1:0]     cur_i, cur_j, cur_k;
    logic [DATA_W-1:0] m_value;
    logic [2:0]        m_index;
    logic              m_sing;

    lup_ctrl #(
        .MAX_N (MAX_N)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser),
        .in_row      (s_tdata[2:0]),
        .in_col      (s_tdata[5:3]),
        .stat        (stat),
        .cmd         (cmd),
        .cur_i       (cur_i),
        .cur_j       (cur_j),
        .cur_k       (cur_k)
    );

    lup_datapath #(
        .MAX_N     (MAX_N),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .cur_i    (cur_i),
        .cur_j    (cur_j),
        .cur_k    (cur_k),
        .in_row   (s_tdata[2:0]),
        .in_col   (s_tdata[5:3]),
        .in_value (s_tdata[37:6]),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_value  (m_value),
        .m_index  (m_index),
        .m_last   (m_tlast),
        .m_sing   (m_sing)
    );

    assign m_tdata = {5'd0, m_index, m_value};
    assign m_tuser = m_sing;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for lup_linear_solver: loads random and directed systems,
// predicts each solve in fixed point and checks every returned solution element.
// Depends on lup_pkg and the lup_linear_solver RTL.
`timescale 1ns / 1ps

module tb;
    import lup_pkg::*;

    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic [1:0]         mode;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
    } request_t;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         index;
        logic               last;
        logic               singular;
    } solution_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [39:0]       s_tdata = '0;
    logic [1:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [39:0]       m_tdata;
    logic              m_tlast;
    logic [0:0]        m_tuser;

    request_t  pending_requests[$];
    solution_t expected_solutions[$];
    request_t  offered;
    int        errors = 0;
    int        cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    logic      hold_req = 1'b0;
    int        hold_cnt = 0;
    int        items_sent = 0;

    // Predictor state.
    int   order_reg = 8;
    int   mtx[8][8];
    int   rhs[8];
    int   work[8];
    int   perm[8];
    // Which entries the stimulus has loaded since reset.
    bit   mtx_loaded[8][8];
    bit   rhs_loaded[8];

    lup_linear_solver DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic int q_mul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat32(p >>> 16);
    endfunction

    function automatic int q_div(int num, int den);
        longint scaled;
        scaled = longint'(num) * 64'sd65536;
        return sat32(scaled / longint'(den));
    endfunction

    function automatic int q_sub(int a, int b);
        return sat32(longint'(a) - longint'(b));
    endfunction

    function automatic longint mag(int v);
        return v < 0 ? -longint'(v) : longint'(v);
    endfunction

    // In-place LU with partial pivoting; returns 0 on an all-zero pivot column.
    function automatic bit lu_factor(int n);
        int k, i, j, pick, t;
        longint best;
        for (i = 0; i < n; i++) perm[i] = i;
        for (k = 0; k < n; k++) begin
            best = 0;
            pick = k;
            for (i = k; i < n; i++) begin
                if (mag(mtx[i][k]) > best) begin
                    best = mag(mtx[i][k]);
                    pick = i;
                end
            end
            if (best == 0) return 1'b0;
            if (pick != k) begin
                t = perm[k]; perm[k] = perm[pick]; perm[pick] = t;
                for (j = 0; j < n; j++) begin
                    t = mtx[pick][j]; mtx[pick][j] = mtx[k][j]; mtx[k][j] = t;
                end
            end
            for (i = k + 1; i < n; i++) begin
                mtx[i][k] = q_div(mtx[i][k], mtx[k][k]);
                for (j = k + 1; j < n; j++)
                    mtx[i][j] = q_sub(mtx[i][j], q_mul(mtx[i][k], mtx[k][j]));
            end
        end
        return 1'b1;
    endfunction

    task automatic predict_solve();
        int n, i, j, acc;
        bit ok;
        solution_t s;
        n = order_reg < 1 ? 1 : (order_reg > 8 ? 8 : order_reg);
        ok = lu_factor(n);
        if (ok) begin
            for (i = 0; i < n; i++) begin
                acc = rhs[perm[i]];
                for (j = 0; j < i; j++) acc = q_sub(acc, q_mul(mtx[i][j], work[j]));
                work[i] = acc;
            end
            for (i = n - 1; i >= 0; i--) begin
                acc = work[i];
                for (j = i + 1; j < n; j++) acc = q_sub(acc, q_mul(mtx[i][j], work[j]));
                work[i] = q_div(acc, mtx[i][i]);
            end
        end
        for (i = 0; i < n; i++) begin
            s.value = ok ? work[i] : 0;
            s.index = i[2:0];
            s.last = (i == n - 1);
            s.singular = !ok;
            expected_solutions.push_back(s);
        end
    endtask

    task automatic apply_request(request_t r);
        case (r.mode)
            MODE_MTX: mtx[r.row][r.col] = r.value;
            MODE_RHS: rhs[r.row] = r.value;
            MODE_SOLVE: predict_solve();
            default: ;
        endcase
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    // Driver: a request stays offered until accepted.
    always @(posedge aclk) begin
        request_t r;
        if (aresetn && (!s_tvalid || s_tready)) begin
            if (s_tvalid) apply_request(offered);
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                r = pending_requests.pop_front();
                offered = r;
                s_tvalid <= 1'b1;
                s_tdata <= {2'b00, r.value, r.col, r.row};
                s_tuser <= r.mode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here while hold_req is raised.
    always @(posedge aclk) begin
        if (hold_req && hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
    end

    // Monitor.
    always @(posedge aclk) begin
        solution_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_solutions.size() == 0) begin
                $display("unexpected solution at cycle %0d", cycles);
                errors++;
            end else begin
                e = expected_solutions.pop_front();
                if ($signed(m_tdata[31:0]) != e.value)
                    report("solution_value", $signed(m_tdata[31:0]), e.value);
                if (m_tdata[34:32] != e.index)
                    report("solution_index", m_tdata[34:32], e.index);
                if (m_tlast != e.last) report("last_of_run", m_tlast, e.last);
                if (m_tuser[0] != e.singular) report("singular", m_tuser[0], e.singular);
            end
        end
        m_tready <= aresetn && !(hold_req && hold_cnt < HOLD_CYCLES)
                    && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send(logic [1:0] mode, int row, int col, int value);
        request_t r;
        r.mode = mode;
        r.row = row[2:0];
        r.col = col[2:0];
        r.value = value;
        if (mode == MODE_MTX) mtx_loaded[row][col] = 1'b1;
        if (mode == MODE_RHS) rhs_loaded[row] = 1'b1;
        pending_requests.push_back(r);
        items_sent++;
    endtask

    function automatic int rand_entry(int kind);
        case (kind)
            0: return int'($urandom);
            1: return int'($urandom_range(0, 524287)) - 262144;
            2: return 0;
            default: begin
                case ($urandom_range(3))
                    0: return 32'sh80000000;
                    1: return 32'sh7fffffff;
                    2: return 32'sh00010000;
                    default: return -32'sd65536;
                endcase
            end
        endcase
    endfunction

    function automatic int order_used();
        return order_reg < 1 ? 1 : (order_reg > 8 ? 8 : order_reg);
    endfunction

    // A load of up to n x n coefficients and n right-hand entries (all on a full load), then a solve.
    task automatic send_system(bit full_load);
        int n, i, j, kind, zcol, v;
        n = order_used();
        kind = $urandom_range(9);
        zcol = ($urandom_range(9) == 0) ? int'($urandom_range(n - 1)) : -1;
        for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
                if (full_load || !mtx_loaded[i][j] || $urandom_range(2) == 0) begin
                    if (j == zcol) v = 0;
                    else if (kind < 6) v = rand_entry(1) + ((i == j) ? 32'sd1048576 : 0);
                    else v = rand_entry($urandom_range(3));
                    send(MODE_MTX, i, j, v);
                end
            end
            if (full_load || !rhs_loaded[i] || $urandom_range(1) == 0)
                send(MODE_RHS, i, 0, rand_entry(kind < 6 ? 1 : $urandom_range(3)));
            if ($urandom_range(15) == 0)
                send(MODE_NOP, $urandom_range(7), $urandom_range(7), rand_entry(0));
        end
        send(MODE_SOLVE, $urandom_range(7), $urandom_range(7), rand_entry(0));
        // Sometimes solve again on the factored matrix left in place.
        if ($urandom_range(5) == 0)
            send(MODE_SOLVE, $urandom_range(7), $urandom_range(7), rand_entry(0));
    endtask

    task automatic wait_idle(int settle);
        while (pending_requests.size() > 0 || s_tvalid || expected_solutions.size() > 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_order(int value);
        wait_idle(60);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[SIZE_W-1:0];
        order_reg = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
    endtask

    initial begin
        int orders[8] = '{8, 1, 0, 15, 3, 5, 2, 7};
        int p, target;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Order 8 from reset, full load first so every later read is defined.
        set_idling(0);
        send_system(1'b1);
        send_system(1'b0);

        // Directed: order 1 with zero, extreme and saturating cases.
        write_order(1);
        send(MODE_MTX, 0, 0, 0);
        send(MODE_RHS, 0, 0, 32'sh00010000);
        send(MODE_SOLVE, 0, 0, 0);
        send(MODE_MTX, 0, 0, 32'sh7fffffff);
        send(MODE_RHS, 0, 0, 32'sh80000000);
        send(MODE_SOLVE, 7, 7, -1);
        send(MODE_MTX, 0, 0, 1);
        send(MODE_RHS, 0, 0, 32'sh7fffffff);
        send(MODE_SOLVE, 0, 0, 0);
        send(MODE_MTX, 0, 0, -1);
        send(MODE_RHS, 0, 0, 32'sh80000000);
        send(MODE_NOP, 7, 7, 32'sh7fffffff);
        send(MODE_SOLVE, 0, 0, 0);
        send(MODE_MTX, 7, 7, 32'sh80000000);
        send(MODE_RHS, 7, 0, -32'sd65536);
        send(MODE_MTX, 0, 0, 32'sh80000000);
        send(MODE_SOLVE, 0, 0, 0);

        for (p = 0; p < 8; p++) begin
            write_order(orders[(p + 1) % 8]);
            set_idling(p);
            if (p == 2) hold_req = 1'b1;
            target = items_sent + 45;
            while (items_sent < target) send_system(1'b0);
            wait_idle(0);
            hold_req = 1'b0;
        end
        set_idling(0);
        write_order(8);
        send_system(1'b0);

        wait_idle(200);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
